// File: rtl/h2rgb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// h2rgb_pkg
// Shared field widths, hue constants and the hue sector code for the
// HSV/HSL to RGB converter.
// ============================================================================
package h2rgb_pkg;

    // Widths of the stream fields.
    localparam int HUE_W   = 16;
    localparam int CHAN_W  = 13;
    localparam int TDATA_W = 56;

    // Hue geometry in whole degrees.
    localparam int TURN_DEG   = 360;
    localparam int SECTOR_DEG = 60;

    // The six 60-degree hue sectors, named by the colors at their edges.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

endpackage

// File: rtl/h2rgb_front.sv
`timescale 1ns / 1ps
// ============================================================================
// h2rgb_front
// First two pipeline stages: chroma and offset from saturation and level,
// and reduction of the hue to one full turn.
// ============================================================================
module h2rgb_front import h2rgb_pkg::*; #(
    parameter int CHANNEL_FRAC_BITS = 12,
    parameter int HUE_FRAC_BITS     = 7
) (
    input  logic                         aclk,
    input  logic [1:0]                   stage_en,
    input  logic                         hsl_in,
    input  logic [HUE_W-1:0]             hue_in,
    input  logic [CHAN_W-1:0]            sat_in,
    input  logic [CHAN_W-1:0]            level_in,
    input  logic [CHAN_W-1:0]            alpha_in,
    output logic [CHANNEL_FRAC_BITS:0]   chroma_reg,
    output logic [CHANNEL_FRAC_BITS+1:0] offset2_reg,
    output logic [HUE_W-1:0]             hue_mod_reg,
    output logic [CHAN_W-1:0]            alpha_reg
);

    localparam int CW   = CHANNEL_FRAC_BITS + 1;
    localparam int EXTW = (CW > CHAN_W) ? CW : CHAN_W;
    localparam int PW   = 2 * CW;
    localparam logic [CW-1:0]   ONE      = {1'b1, {CHANNEL_FRAC_BITS{1'b0}}};
    localparam logic [EXTW-1:0] ONE_EXT  = EXTW'(ONE);
    localparam logic [CW:0]     ONE2     = (CW + 1)'(ONE);
    localparam logic [PW-1:0]   HALF_LSB = PW'(ONE >> 1);

    // Turn count by a reciprocal multiply; exact for every 16-bit hue.
    localparam int RECIP_SHIFT  = 34;
    localparam int TURN_COUNT_W = 8;
    localparam int TPW          = RECIP_SHIFT + TURN_COUNT_W;
    localparam longint unsigned TURN  = longint'(TURN_DEG) << HUE_FRAC_BITS;
    localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + TURN - 1) / TURN;

    logic [EXTW-1:0]         sat_ext;
    logic [EXTW-1:0]         lvl_ext;
    logic [CW-1:0]           sat_c;
    logic [CW-1:0]           lvl_c;
    logic [CW:0]             two_l;
    logic [CW:0]             dev;
    logic [CW-1:0]           span;
    logic [CW-1:0]           mult_a;
    logic [PW-1:0]           chroma_prod;
    logic [TPW-1:0]          turn_prod;

    logic                    hsl_s0_reg;
    logic [CW-1:0]           lvl_s0_reg;
    logic [PW-1:0]           prod_s0_reg;
    logic [HUE_W-1:0]        hue_s0_reg;
    logic [TURN_COUNT_W-1:0] turns_s0_reg;
    logic [CHAN_W-1:0]       alpha_s0_reg;

    logic [PW-1:0]           chroma_sum;
    logic [CW-1:0]           chroma_next;
    logic [CW:0]             chroma_ext;
    logic [CW:0]             two_l1;
    logic [CW:0]             offset2_next;
    logic [HUE_W-1:0]        turn_base;
    logic [HUE_W-1:0]        hue_mod_next;

    // Stage 0: saturate the inputs, form the span and start both multiplies.
    always_comb begin
        sat_ext     = EXTW'(sat_in);
        lvl_ext     = EXTW'(level_in);
        sat_c       = (sat_ext > ONE_EXT) ? ONE : sat_ext[CW-1:0];
        lvl_c       = (lvl_ext > ONE_EXT) ? ONE : lvl_ext[CW-1:0];
        two_l       = {lvl_c, 1'b0};
        dev         = (two_l >= ONE2) ? (two_l - ONE2) : (ONE2 - two_l);
        span        = ONE - dev[CW-1:0];
        mult_a      = hsl_in ? span : lvl_c;
        chroma_prod = PW'(mult_a) * PW'(sat_c);
        turn_prod   = TPW'(hue_in) * TPW'(RECIP);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            hsl_s0_reg   <= hsl_in;
            lvl_s0_reg   <= lvl_c;
            prod_s0_reg  <= chroma_prod;
            hue_s0_reg   <= hue_in;
            turns_s0_reg <= turn_prod[RECIP_SHIFT +: TURN_COUNT_W];
            alpha_s0_reg <= alpha_in;
        end
    end

    // Stage 1: round the chroma, derive twice the offset, fold the hue.
    always_comb begin
        chroma_sum  = prod_s0_reg + HALF_LSB;
        chroma_next = chroma_sum[CHANNEL_FRAC_BITS +: CW];
        chroma_ext  = (CW + 1)'(chroma_next);
        two_l1      = {lvl_s0_reg, 1'b0};
        if (hsl_s0_reg) begin
            offset2_next = (chroma_ext > two_l1) ? '0 : (two_l1 - chroma_ext);
        end else begin
            offset2_next = (chroma_next > lvl_s0_reg) ? '0 :
                           {lvl_s0_reg - chroma_next, 1'b0};
        end
        turn_base    = HUE_W'(32'(turns_s0_reg) * 32'(TURN));
        hue_mod_next = hue_s0_reg - turn_base;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            chroma_reg  <= chroma_next;
            offset2_reg <= offset2_next;
            hue_mod_reg <= hue_mod_next;
            alpha_reg   <= alpha_s0_reg;
        end
    end

endmodule

// File: rtl/h2rgb_sector.sv
`timescale 1ns / 1ps
// ============================================================================
// h2rgb_sector
// Third pipeline stage: splits the reduced hue into a sector and the
// distance that scales the secondary component.
// ============================================================================
module h2rgb_sector import h2rgb_pkg::*; #(
    parameter int CHANNEL_FRAC_BITS = 12,
    parameter int HUE_FRAC_BITS     = 7
) (
    input  logic                                   aclk,
    input  logic                                   stage_en,
    input  logic [CHANNEL_FRAC_BITS:0]             chroma_in,
    input  logic [CHANNEL_FRAC_BITS+1:0]           offset2_in,
    input  logic [HUE_W-1:0]                       hue_mod_in,
    input  logic [CHAN_W-1:0]                      alpha_in,
    output sector_t                                sector_reg,
    output logic [$clog2((SECTOR_DEG << HUE_FRAC_BITS) + 1)-1:0] dist_reg,
    output logic [CHANNEL_FRAC_BITS:0]             chroma_reg,
    output logic [CHANNEL_FRAC_BITS+1:0]           offset2_reg,
    output logic [CHAN_W-1:0]                      alpha_reg
);

    localparam int SECTOR = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int TW     = $clog2(SECTOR + 1);
    localparam int HW     = HUE_W + 1;
    localparam logic [HW-1:0] B1 = HW'(1 * SECTOR);
    localparam logic [HW-1:0] B2 = HW'(2 * SECTOR);
    localparam logic [HW-1:0] B3 = HW'(3 * SECTOR);
    localparam logic [HW-1:0] B4 = HW'(4 * SECTOR);
    localparam logic [HW-1:0] B5 = HW'(5 * SECTOR);
    localparam logic [TW-1:0] SECTOR_T = TW'(SECTOR);

    logic [HW-1:0] h_ext;
    logic [HW-1:0] base;
    logic [HW-1:0] frac_wide;
    logic          odd;
    sector_t       sector_next;
    logic [TW-1:0] dist_next;

    // Sector search by threshold compares; odd sectors count down.
    always_comb begin
        h_ext = HW'(hue_mod_in);
        priority if (h_ext < B1) begin
            sector_next = SEC_RED_YELLOW;
            base        = '0;
            odd         = 1'b0;
        end else if (h_ext < B2) begin
            sector_next = SEC_YELLOW_GREEN;
            base        = B1;
            odd         = 1'b1;
        end else if (h_ext < B3) begin
            sector_next = SEC_GREEN_CYAN;
            base        = B2;
            odd         = 1'b0;
        end else if (h_ext < B4) begin
            sector_next = SEC_CYAN_BLUE;
            base        = B3;
            odd         = 1'b1;
        end else if (h_ext < B5) begin
            sector_next = SEC_BLUE_MAGENTA;
            base        = B4;
            odd         = 1'b0;
        end else begin
            sector_next = SEC_MAGENTA_RED;
            base        = B5;
            odd         = 1'b1;
        end
        frac_wide = h_ext - base;
        dist_next = odd ? (SECTOR_T - frac_wide[TW-1:0]) : frac_wide[TW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            sector_reg  <= sector_next;
            dist_reg    <= dist_next;
            chroma_reg  <= chroma_in;
            offset2_reg <= offset2_in;
            alpha_reg   <= alpha_in;
        end
    end

endmodule

// File: rtl/h2rgb_blend.sv
`timescale 1ns / 1ps
// ============================================================================
// h2rgb_blend
// Last three pipeline stages: secondary component, channel placement,
// offset, rounding and clamping.
// ============================================================================
module h2rgb_blend import h2rgb_pkg::*; #(
    parameter int CHANNEL_FRAC_BITS = 12,
    parameter int HUE_FRAC_BITS     = 7
) (
    input  logic                                   aclk,
    input  logic [2:0]                             stage_en,
    input  sector_t                                sector_in,
    input  logic [$clog2((SECTOR_DEG << HUE_FRAC_BITS) + 1)-1:0] dist_in,
    input  logic [CHANNEL_FRAC_BITS:0]             chroma_in,
    input  logic [CHANNEL_FRAC_BITS+1:0]           offset2_in,
    input  logic [CHAN_W-1:0]                      alpha_in,
    output logic [CHAN_W-1:0]                      red_reg,
    output logic [CHAN_W-1:0]                      green_reg,
    output logic [CHAN_W-1:0]                      blue_reg,
    output logic [CHAN_W-1:0]                      opacity_reg
);

    localparam int CW     = CHANNEL_FRAC_BITS + 1;
    localparam int EXTW   = (CW > CHAN_W) ? CW : CHAN_W;
    localparam int SECTOR = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int TW     = $clog2(SECTOR + 1);
    localparam int YW     = CW + TW;
    localparam int ZW     = YW - HUE_FRAC_BITS;
    // Division by 60 through a reciprocal, exact for every ZW-bit value.
    localparam int RSHIFT = ZW + 6;
    localparam int XPW    = RSHIFT + CW;
    localparam longint unsigned RECIP60 =
        ((64'd1 << RSHIFT) + SECTOR_DEG - 1) / SECTOR_DEG;
    localparam logic [YW-1:0] HALF_SECTOR = YW'(SECTOR / 2);
    localparam logic [CW-1:0] ONE = {1'b1, {CHANNEL_FRAC_BITS{1'b0}}};

    logic [YW-1:0]      prod_next;
    logic [YW-1:0]      prod_s3_reg;
    sector_t            sector_s3_reg;
    logic [CW-1:0]      chroma_s3_reg;
    logic [CW:0]        offset2_s3_reg;
    logic [CHAN_W-1:0]  alpha_s3_reg;

    logic [ZW-1:0]      quot_in;
    logic [XPW-1:0]     quot_prod;
    logic [CW-1:0]      second_s4_reg;
    sector_t            sector_s4_reg;
    logic [CW-1:0]      chroma_s4_reg;
    logic [CW:0]        offset2_s4_reg;
    logic [CHAN_W-1:0]  alpha_s4_reg;

    logic [CW-1:0]      r_comp;
    logic [CW-1:0]      g_comp;
    logic [CW-1:0]      b_comp;

    // Adds half the offset, rounds half up, clamps to one and masks to the field.
    function automatic logic [CHAN_W-1:0] finish(input logic [CW-1:0] comp,
                                                 input logic [CW:0] offset2);
        logic [CW+1:0] sum;
        logic [CW:0]   rounded;
        logic [CW-1:0] clamped;
        logic [EXTW-1:0] wide;
        sum     = (CW + 2)'({comp, 1'b0}) + (CW + 2)'(offset2) + (CW + 2)'(1);
        rounded = sum[CW+1:1];
        clamped = (rounded > (CW + 1)'(ONE)) ? ONE : rounded[CW-1:0];
        wide    = EXTW'(clamped);
        return wide[CHAN_W-1:0];
    endfunction

    // Stage 3: chroma times hue distance, with the rounding term added.
    assign prod_next = YW'(chroma_in) * YW'(dist_in) + HALF_SECTOR;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            prod_s3_reg    <= prod_next;
            sector_s3_reg  <= sector_in;
            chroma_s3_reg  <= chroma_in;
            offset2_s3_reg <= offset2_in;
            alpha_s3_reg   <= alpha_in;
        end
    end

    // Stage 4: divide by the sector size as a shift and a reciprocal multiply.
    always_comb begin
        quot_in   = prod_s3_reg[HUE_FRAC_BITS +: ZW];
        quot_prod = XPW'(quot_in) * XPW'(RECIP60);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            second_s4_reg  <= quot_prod[RSHIFT +: CW];
            sector_s4_reg  <= sector_s3_reg;
            chroma_s4_reg  <= chroma_s3_reg;
            offset2_s4_reg <= offset2_s3_reg;
            alpha_s4_reg   <= alpha_s3_reg;
        end
    end

    // Stage 5: place chroma and secondary component by sector.
    always_comb begin
        unique case (sector_s4_reg)
            SEC_RED_YELLOW: begin
                r_comp = chroma_s4_reg;
                g_comp = second_s4_reg;
                b_comp = '0;
            end
            SEC_YELLOW_GREEN: begin
                r_comp = second_s4_reg;
                g_comp = chroma_s4_reg;
                b_comp = '0;
            end
            SEC_GREEN_CYAN: begin
                r_comp = '0;
                g_comp = chroma_s4_reg;
                b_comp = second_s4_reg;
            end
            SEC_CYAN_BLUE: begin
                r_comp = '0;
                g_comp = second_s4_reg;
                b_comp = chroma_s4_reg;
            end
            SEC_BLUE_MAGENTA: begin
                r_comp = second_s4_reg;
                g_comp = '0;
                b_comp = chroma_s4_reg;
            end
            default: begin
                r_comp = chroma_s4_reg;
                g_comp = '0;
                b_comp = second_s4_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            red_reg     <= finish(r_comp, offset2_s4_reg);
            green_reg   <= finish(g_comp, offset2_s4_reg);
            blue_reg    <= finish(b_comp, offset2_s4_reg);
            opacity_reg <= alpha_s4_reg;
        end
    end

endmodule

// File: rtl/hsv_hsl_to_rgb.sv
`timescale 1ns / 1ps
// ============================================================================
// hsv_hsl_to_rgb
// Streaming HSV/HSL to RGB color converter with alpha pass-through.
// ============================================================================
// One color enters per transfer on the s_ channel: s_tuser selects the input
// model (0 HSV, 1 HSL) and s_tdata carries hue, saturation, level and alpha.
// One RGB color with the unchanged alpha leaves per transfer on the m_ channel.
// The datapath is a six-stage pipeline with a valid bit per stage; a color
// reaches m_tdata once it has passed through every stage, and while m_tready
// stays high a new color can be taken every cycle (one item per clock).
// The stage depth is set by the two reciprocal multiplies (hue reduction and
// the divide by the sector size) and by the chroma-times-distance multiply.
// When the receiver stalls, each stage holds until the next one frees up, so
// empty stages ahead of the stall keep filling and s_tready only drops once
// every stage holds a color; nothing is dropped or repeated.
// A synchronous low aresetn empties the pipeline; the block is ready for input
// in the first cycle after reset. There are no configuration registers.
// ============================================================================
module hsv_hsl_to_rgb import h2rgb_pkg::*; #(
    parameter int CHANNEL_FRAC_BITS = 12,
    parameter int HUE_FRAC_BITS     = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [15:0] hue, [28:16] saturation, [41:29] level, [54:42] alpha, [55] zero
    input  logic [TDATA_W-1:0] s_tdata,
    // [0] operation
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [12:0] red, [25:13] green, [38:26] blue, [51:39] opacity, [55:52] zero
    output logic [TDATA_W-1:0] m_tdata
);

    localparam int NUM_STAGES = 6;
    localparam int CW = CHANNEL_FRAC_BITS + 1;
    localparam int TW = $clog2((SECTOR_DEG << HUE_FRAC_BITS) + 1);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_in_valid;
    logic [NUM_STAGES:0]   stage_ready;
    logic [NUM_STAGES-1:0] stage_en;

    logic [CW-1:0]     chroma_s1;
    logic [CW:0]       offset2_s1;
    logic [HUE_W-1:0]  hue_mod_s1;
    logic [CHAN_W-1:0] alpha_s1;
    sector_t           sector_s2;
    logic [TW-1:0]     dist_s2;
    logic [CW-1:0]     chroma_s2;
    logic [CW:0]       offset2_s2;
    logic [CHAN_W-1:0] alpha_s2;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] opacity;

    // Per-stage flow control: a stage loads when it is empty or moves on.
    always_comb begin
        stage_ready[NUM_STAGES] = m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        stage_in_valid = {valid_reg[NUM_STAGES-2:0], s_tvalid};
        stage_en       = stage_in_valid & stage_ready[NUM_STAGES-1:0];
        for (int k = 0; k < NUM_STAGES; k++) begin
            valid_next[k] = stage_ready[k] ? stage_in_valid[k] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    h2rgb_front #(
        .CHANNEL_FRAC_BITS (CHANNEL_FRAC_BITS),
        .HUE_FRAC_BITS     (HUE_FRAC_BITS)
    ) u_front (
        .aclk        (aclk),
        .stage_en    (stage_en[1:0]),
        .hsl_in      (s_tuser),
        .hue_in      (s_tdata[15:0]),
        .sat_in      (s_tdata[28:16]),
        .level_in    (s_tdata[41:29]),
        .alpha_in    (s_tdata[54:42]),
        .chroma_reg  (chroma_s1),
        .offset2_reg (offset2_s1),
        .hue_mod_reg (hue_mod_s1),
        .alpha_reg   (alpha_s1)
    );

    h2rgb_sector #(
        .CHANNEL_FRAC_BITS (CHANNEL_FRAC_BITS),
        .HUE_FRAC_BITS     (HUE_FRAC_BITS)
    ) u_sector (
        .aclk        (aclk),
        .stage_en    (stage_en[2]),
        .chroma_in   (chroma_s1),
        .offset2_in  (offset2_s1),
        .hue_mod_in  (hue_mod_s1),
        .alpha_in    (alpha_s1),
        .sector_reg  (sector_s2),
        .dist_reg    (dist_s2),
        .chroma_reg  (chroma_s2),
        .offset2_reg (offset2_s2),
        .alpha_reg   (alpha_s2)
    );

    h2rgb_blend #(
        .CHANNEL_FRAC_BITS (CHANNEL_FRAC_BITS),
        .HUE_FRAC_BITS     (HUE_FRAC_BITS)
    ) u_blend (
        .aclk        (aclk),
        .stage_en    (stage_en[5:3]),
        .sector_in   (sector_s2),
        .dist_in     (dist_s2),
        .chroma_in   (chroma_s2),
        .offset2_in  (offset2_s2),
        .alpha_in    (alpha_s2),
        .red_reg     (red),
        .green_reg   (green),
        .blue_reg    (blue),
        .opacity_reg (opacity)
    );

    // Pack the result fields, lowest first.
    assign m_tdata = {4'b0000, opacity, blue, green, red};

endmodule

// File: rtl/h2rgb_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// h2rgb_checker
// Port-level checks on the converter's stream channels, bound to the top.
// ============================================================================
module h2rgb_checker import h2rgb_pkg::*; #(
    parameter int CHANNEL_FRAC_BITS = 12
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    localparam logic [CHAN_W:0] LIMIT = (CHANNEL_FRAC_BITS >= CHAN_W) ?
        (CHAN_W + 1)'((1 << CHAN_W) - 1) : (CHAN_W + 1)'(1 << CHANNEL_FRAC_BITS);

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // A held result stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // With the output free to move, the input side must be ready to take a transfer.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while the output is free");

    // A color reaches the output within the pipeline depth when unstalled.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("result missing after the pipeline depth");

    // Every color channel stays within 0 to 1.0.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((CHAN_W + 1)'(m_tdata[12:0]) <= LIMIT) &&
                     ((CHAN_W + 1)'(m_tdata[25:13]) <= LIMIT) &&
                     ((CHAN_W + 1)'(m_tdata[38:26]) <= LIMIT))
        else $error("color channel above full scale");

endmodule

bind hsv_hsl_to_rgb h2rgb_checker #(
    .CHANNEL_FRAC_BITS (CHANNEL_FRAC_BITS)
) u_h2rgb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the streaming HSV/HSL to RGB converter.
// ============================================================================
// Colors go in on the s_ stream. Every input transfer is seen by a monitor,
// which works out the expected red, green, blue and opacity in fixed point and
// queues them. Each m_ transfer is compared field by field with the oldest
// queued color. The run has a directed part (hue wrap and sector edges,
// out-of-range saturation, level and alpha, both color models), a long
// random part with gaps on both sides, a long receiver hold-off that fills
// the pipeline, and a gap-free streaming part at the end.
// ============================================================================
module tb_top import h2rgb_pkg::*; ();

    // Fixed-point formats of the block (its parameter defaults).
    localparam int CH_FRAC     = 12;
    localparam int HUE_FRAC    = 7;
    localparam int CH_ONE      = 1 << CH_FRAC;
    localparam int HUE_TURN    = TURN_DEG << HUE_FRAC;
    localparam int HUE_SECTOR  = SECTOR_DEG << HUE_FRAC;
    localparam int CHAN_MASK   = (1 << CHAN_W) - 1;

    // Color model codes carried in s_tuser.
    localparam bit OP_HSV = 1'b0;
    localparam bit OP_HSL = 1'b1;

    // Run control.
    localparam int RANDOM_ITEMS  = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int STREAM_ITEMS  = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_PRINTED   = 20;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] opacity;
    } rgba_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;

    rgba_t expected_colors[$];
    int    error_count;
    int    colors_sent;
    int    colors_checked;
    int    hsl_sent;
    int    input_stalls;
    int    idle_cycles = 0;
    bit    sender_gaps;
    bit    receiver_gaps;
    int    hold_request;

    hsv_hsl_to_rgb u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Rounds comp plus half of m2 half up and clamps it to one.
    function automatic logic [CHAN_W-1:0] add_offset(int unsigned comp, int unsigned m2);
        int unsigned sum;
        sum = (2 * comp + m2 + 1) >> 1;
        if (sum > CH_ONE) begin
            sum = CH_ONE;
        end
        return CHAN_W'(sum & CHAN_MASK);
    endfunction

    // Fixed-point HSV/HSL to RGB conversion of one color.
    function automatic rgba_t convert_color(bit model, logic [HUE_W-1:0] hue,
                                            logic [CHAN_W-1:0] sat_in,
                                            logic [CHAN_W-1:0] lvl_in,
                                            logic [CHAN_W-1:0] alpha);
        int unsigned h, s, l, f, chroma, m2, ramp, x, two_l, dev, span;
        int unsigned r, g, b;
        sector_t     sec;
        rgba_t       res;
        h   = hue % HUE_TURN;
        s   = (sat_in > CH_ONE) ? CH_ONE : sat_in;
        l   = (lvl_in > CH_ONE) ? CH_ONE : lvl_in;
        sec = sector_t'(h / HUE_SECTOR);
        f   = h % HUE_SECTOR;

        if (model == OP_HSL) begin
            two_l  = 2 * l;
            dev    = (two_l >= CH_ONE) ? two_l - CH_ONE : CH_ONE - two_l;
            span   = CH_ONE - dev;
            chroma = (span * s + (CH_ONE >> 1)) >> CH_FRAC;
            m2     = (chroma > two_l) ? 0 : two_l - chroma;
        end else begin
            chroma = (l * s + (CH_ONE >> 1)) >> CH_FRAC;
            m2     = (chroma > l) ? 0 : 2 * (l - chroma);
        end

        // Odd sectors fall from chroma toward zero, even ones rise.
        ramp = sec[0] ? HUE_SECTOR - f : f;
        x    = (chroma * ramp + (HUE_SECTOR >> 1)) / HUE_SECTOR;

        unique case (sec)
            SEC_RED_YELLOW:   begin r = chroma; g = x;      b = 0;      end
            SEC_YELLOW_GREEN: begin r = x;      g = chroma; b = 0;      end
            SEC_GREEN_CYAN:   begin r = 0;      g = chroma; b = x;      end
            SEC_CYAN_BLUE:    begin r = 0;      g = x;      b = chroma; end
            SEC_BLUE_MAGENTA: begin r = x;      g = 0;      b = chroma; end
            default:          begin r = chroma; g = 0;      b = x;      end
        endcase

        res.red     = add_offset(r, m2);
        res.green   = add_offset(g, m2);
        res.blue    = add_offset(b, m2);
        res.opacity = alpha;
        return res;
    endfunction

    // Prints one mismatch (up to a cap) and counts it.
    task automatic report_mismatch(string what, logic [CHAN_W-1:0] got,
                                   logic [CHAN_W-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("ERROR: color %0d %s got %0d expected %0d at %0t",
                     colors_checked, what, got, want, $time);
        end
    endtask

    // Input and output monitor. Values are read just after the edge, before
    // any update of that edge lands, so they are the ones the block sampled.
    always @(posedge aclk) begin
        rgba_t want;
        if (s_tvalid && s_tready) begin
            expected_colors.push_back(convert_color(s_tuser, s_tdata[15:0],
                                                    s_tdata[28:16], s_tdata[41:29],
                                                    s_tdata[54:42]));
        end
        if (s_tvalid && !s_tready) begin
            input_stalls++;
        end
        if (m_tvalid && m_tready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch("unexpected transfer, red", m_tdata[12:0], '0);
            end else begin
                want = expected_colors.pop_front();
                if (m_tdata[12:0] !== want.red) begin
                    report_mismatch("red", m_tdata[12:0], want.red);
                end
                if (m_tdata[25:13] !== want.green) begin
                    report_mismatch("green", m_tdata[25:13], want.green);
                end
                if (m_tdata[38:26] !== want.blue) begin
                    report_mismatch("blue", m_tdata[38:26], want.blue);
                end
                if (m_tdata[51:39] !== want.opacity) begin
                    report_mismatch("opacity", m_tdata[51:39], want.opacity);
                end
                colors_checked++;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offers one color and returns at the edge where it is taken.
    task automatic send_color(bit model, logic [HUE_W-1:0] hue, logic [CHAN_W-1:0] sat,
                              logic [CHAN_W-1:0] lvl, logic [CHAN_W-1:0] alpha);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= model;
        s_tdata  <= {1'b0, alpha, lvl, sat, hue};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        colors_sent++;
        if (model == OP_HSL) begin
            hsl_sent++;
        end
    endtask

    // Mostly in-range channel values, sometimes the full 13-bit field.
    function automatic logic [CHAN_W-1:0] random_channel();
        if ($urandom_range(0, 4) == 0) begin
            return CHAN_W'($urandom_range(0, CHAN_MASK));
        end
        return CHAN_W'($urandom_range(0, CH_ONE));
    endfunction

    // Hue within one turn half the time, any 16-bit code otherwise.
    function automatic logic [HUE_W-1:0] random_hue();
        if ($urandom_range(0, 1) == 0) begin
            return HUE_W'($urandom_range(0, HUE_TURN - 1));
        end
        return HUE_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Random color model.
    function automatic bit random_model();
        return 1'($urandom_range(0, 1));
    endfunction

    // Directed colors: hue wrap and sector edges, range extremes, both models.
    task automatic test_directed();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        send_color(OP_HSV, 16'd0,                  13'd4096, 13'd4096, 13'd4096);
        send_color(OP_HSV, HUE_W'(HUE_TURN - 1),   13'd4096, 13'd4096, 13'd0);
        send_color(OP_HSV, HUE_W'(HUE_TURN),       13'd4096, 13'd4096, 13'd8191);
        send_color(OP_HSV, 16'hFFFF,               13'd4096, 13'd4096, 13'd1234);
        send_color(OP_HSV, HUE_W'(HUE_SECTOR),     13'd4096, 13'd4096, 13'd4096);
        send_color(OP_HSV, HUE_W'(HUE_SECTOR - 1), 13'd4096, 13'd4096, 13'd4096);
        send_color(OP_HSV, HUE_W'(2 * HUE_SECTOR), 13'd2048, 13'd3000, 13'd4096);
        send_color(OP_HSV, HUE_W'(3 * HUE_SECTOR), 13'd4096, 13'd4096, 13'd4096);
        send_color(OP_HSV, HUE_W'(4 * HUE_SECTOR), 13'd4096, 13'd4096, 13'd4096);
        send_color(OP_HSV, HUE_W'(5 * HUE_SECTOR + 3840), 13'd4096, 13'd4096, 13'd4096);
        send_color(OP_HSV, 16'd1000,               13'd0,    13'd4096, 13'd4096);
        send_color(OP_HSV, 16'd20000,              13'd4096, 13'd0,    13'd4096);
        // Saturation and level above one saturate before use.
        send_color(OP_HSV, 16'd12345,              13'd8191, 13'd8191, 13'd8191);
        send_color(OP_HSV, 16'd30000,              13'd5000, 13'd2000, 13'd7000);
        send_color(OP_HSL, 16'd0,                  13'd4096, 13'd2048, 13'd4096);
        send_color(OP_HSL, HUE_W'(HUE_SECTOR),     13'd4096, 13'd2048, 13'd0);
        send_color(OP_HSL, HUE_W'(3 * HUE_SECTOR), 13'd4096, 13'd2048, 13'd4096);
        send_color(OP_HSL, 16'hFFFF,               13'd4096, 13'd4096, 13'd4096);
        send_color(OP_HSL, 16'd9000,               13'd4096, 13'd0,    13'd4096);
        send_color(OP_HSL, 16'd40000,              13'd0,    13'd2048, 13'd4096);
        send_color(OP_HSL, 16'd25000,              13'd8191, 13'd8191, 13'd8191);
        send_color(OP_HSL, 16'd17000,              13'd3000, 13'd1000, 13'd2222);
        send_color(OP_HSL, 16'd44000,              13'd2500, 13'd3500, 13'd4095);
        send_color(OP_HSL, HUE_W'(HUE_TURN - 1),   13'd4096, 13'd2049, 13'd1);
    endtask

    // Random colors with random gaps on both sides.
    task automatic test_random();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        repeat (RANDOM_ITEMS) begin
            send_color(random_model(), random_hue(), random_channel(),
                       random_channel(), random_channel());
        end
    endtask

    // The receiver holds off while colors keep coming, so the pipe fills up.
    task automatic test_backpressure();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        hold_request  = HOLD_CYCLES;
        repeat (30) begin
            send_color(random_model(), random_hue(), random_channel(),
                       random_channel(), random_channel());
        end
    endtask

    // Back-to-back colors with no gaps at all.
    task automatic test_streaming();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        repeat (STREAM_ITEMS) begin
            send_color(random_model(), random_hue(), random_channel(),
                       random_channel(), random_channel());
        end
    endtask

    // Main sequence.
    initial begin
        error_count    = 0;
        colors_sent    = 0;
        colors_checked = 0;
        hsl_sent       = 0;
        input_stalls   = 0;
        hold_request   = 0;
        sender_gaps    = 1'b0;
        receiver_gaps  = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_HSV;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random();
        test_backpressure();
        test_streaming();
        s_tvalid <= 1'b0;

        while (expected_colors.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d colors (%0d HSL, %0d HSV), %0d outputs checked.",
                 colors_sent, hsl_sent, colors_sent - hsl_sent, colors_checked);
        $display("Input was held back for %0d cycles; %0d mismatches found.",
                 input_stalls, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
